// ===== sv/bcpe_pkg.sv =====
`timescale 1ns / 1ps
package bcpe_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int IDX_W       = $clog2(BLOCK_BYTES);
  localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
  localparam int BLK_W       = 8 * BLOCK_BYTES;
  localparam int HALF_W      = BLK_W / 2;
  localparam int OUT_DEPTH   = 4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BLOCK_BYTES);

  typedef enum logic [1:0] {
    PAD_PKCS7 = 2'd0,
    PAD_ZERO  = 2'd1,
    PAD_X923  = 2'd2,
    PAD_BAD   = 2'd3
  } pad_mode_e;

  typedef enum logic {
    DIR_ADD    = 1'b0,
    DIR_REMOVE = 1'b1
  } dir_e;

  typedef enum logic {
    REG_PAD_MODE  = 1'b0,
    REG_DIRECTION = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] add_byte;
    logic [7:0] strip_byte;
    logic       ok;
    logic       nz;
  } lane_flags_t;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [CNT_W-1:0] count;
    logic             last;
    logic             err;
  } res_t;

  typedef struct packed {
    logic load;
    logic clr;
  } held_ctrl_t;

endpackage

// ===== sv/block_cipher_padding_engine_core.sv =====
`timescale 1ns / 1ps
// Block padding engine: PKCS#7, zero fill or ANSI X.923 on 16-byte blocks.
// Input channel (in_valid_i/in_ready_o) carries one block, its byte count and
// a last mark. Output channel (out_valid_o/out_ready_i) carries result blocks
// with a count, a last mark and an error flag. Configuration is a plain write
// port (cfg_we_i, cfg_addr_i, cfg_wdata_i): index 0 pad mode, 1 direction;
// write only while no item is in flight.
// Sixteen byte lanes evaluate one block in parallel and a merge stage forms up
// to two results, which enter an output queue of OUT_DEPTH entries in the
// accept cycle. When the queue is empty, out_valid_o rises in the cycle after
// accept. One item is accepted per cycle while the queue has two free entries;
// a full last block in add mode yields two results. In remove mode each full
// block that is not last is held back until the next arrives.
// Reset clears the queue, the held block and both registers (PKCS#7, add).
// When the receiver stalls the queue fills and in_ready_o drops; nothing is
// lost and results leave in order.
module block_cipher_padding_engine_core
  import bcpe_pkg::*;
#(
  parameter int OutDepth = OUT_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [HALF_W-1:0] block_lo_i,
  input  logic [HALF_W-1:0] block_hi_i,
  input  logic [CNT_W-1:0]  byte_count_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [HALF_W-1:0] out_lo_o,
  output logic [HALF_W-1:0] out_hi_o,
  output logic [CNT_W-1:0]  out_count_o,
  output logic              out_last_o,
  output logic              pad_error_o
);

  pad_mode_e        mode_q;
  dir_e             dir_q;
  logic [BLK_W-1:0] held_q;
  logic             held_valid_q, held_valid_d;
  logic [BLK_W-1:0] blk;
  lane_flags_t      lanes [BLOCK_BYTES];
  logic [1:0]       n_res;
  logic [1:0]       push_n;
  res_t             res0, res1, head;
  held_ctrl_t       held_ctrl;
  logic             accept;

  assign blk    = {block_hi_i, block_lo_i};
  assign accept = in_valid_i && in_ready_o;
  assign push_n = accept ? n_res : 2'd0;

  for (genvar g = 0; g < BLOCK_BYTES; g++) begin : g_lane
    bcpe_lane u_lane (
      .data_i    (blk[8*g +: 8]),
      .idx_i     (IDX_W'(g)),
      .count_i   (byte_count_i),
      .mode_i    (mode_q),
      .pad_val_i (blk[BLK_W-1 -: 8]),
      .flags_o   (lanes[g])
    );
  end

  bcpe_merge u_merge (
    .blk_i        (blk),
    .count_i      (byte_count_i),
    .last_i       (last_i),
    .mode_i       (mode_q),
    .dir_i        (dir_q),
    .held_valid_i (held_valid_q),
    .held_blk_i   (held_q),
    .lanes_i      (lanes),
    .n_res_o      (n_res),
    .res0_o       (res0),
    .res1_o       (res1),
    .held_o       (held_ctrl)
  );

  bcpe_ofifo #(
    .Depth (OutDepth)
  ) u_ofifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (res0),
    .push1_i  (res1),
    .room2_o  (in_ready_o),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .head_o   (head)
  );

  assign out_lo_o    = head.blk[HALF_W-1:0];
  assign out_hi_o    = head.blk[BLK_W-1:HALF_W];
  assign out_count_o = head.count;
  assign out_last_o  = head.last;
  assign pad_error_o = head.err;

  always_comb begin
    held_valid_d = held_valid_q;
    if (accept && held_ctrl.load) begin
      held_valid_d = 1'b1;
    end else if (accept && held_ctrl.clr && dir_q == DIR_REMOVE) begin
      held_valid_d = 1'b0;
    end else if (accept && held_ctrl.clr && n_res != 2'd0) begin
      held_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= PAD_PKCS7;
      dir_q        <= DIR_ADD;
      held_valid_q <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      if (cfg_we_i && cfg_addr_i == REG_PAD_MODE) begin
        mode_q <= pad_mode_e'(cfg_wdata_i);
      end
      if (cfg_we_i && cfg_addr_i == REG_DIRECTION) begin
        dir_q <= dir_e'(cfg_wdata_i[0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && held_ctrl.load) begin
      held_q <= blk;
    end
  end

endmodule

// ===== sv/bcpe_lane.sv =====
`timescale 1ns / 1ps
module bcpe_lane
  import bcpe_pkg::*;
(
  input  logic [7:0]       data_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [CNT_W-1:0] count_i,
  input  pad_mode_e        mode_i,
  input  logic [7:0]       pad_val_i,
  output lane_flags_t      flags_o
);

  logic [CNT_W-1:0] add_pv;
  logic             in_data;
  logic             in_pad;
  logic             byte_ok;

  always_comb begin
    add_pv  = FULL_CNT - count_i;
    in_data = {1'b0, idx_i} < count_i;
    in_pad  = (9'(idx_i) + 9'(pad_val_i)) >= 9'(BLOCK_BYTES);
    if (mode_i == PAD_PKCS7) begin
      byte_ok = data_i == pad_val_i;
    end else begin
      byte_ok = data_i == 8'h00;
    end

    if (in_data) begin
      flags_o.add_byte = data_i;
    end else if (mode_i == PAD_PKCS7 || (mode_i == PAD_X923 && idx_i == LAST_IDX)) begin
      flags_o.add_byte = 8'(add_pv);
    end else begin
      flags_o.add_byte = 8'h00;
    end

    flags_o.strip_byte = in_pad ? 8'h00 : data_i;
    flags_o.ok         = !in_pad || idx_i == LAST_IDX || byte_ok;
    flags_o.nz         = data_i != 8'h00;
  end

endmodule

// ===== sv/bcpe_merge.sv =====
`timescale 1ns / 1ps
module bcpe_merge
  import bcpe_pkg::*;
(
  input  logic [BLK_W-1:0]  blk_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic              last_i,
  input  pad_mode_e         mode_i,
  input  dir_e              dir_i,
  input  logic              held_valid_i,
  input  logic [BLK_W-1:0]  held_blk_i,
  input  lane_flags_t       lanes_i [BLOCK_BYTES],
  output logic [1:0]        n_res_o,
  output res_t              res0_o,
  output res_t              res1_o,
  output held_ctrl_t        held_o
);

  logic [BLK_W-1:0] add_blk;
  logic [BLK_W-1:0] strip_blk;
  logic [BLK_W-1:0] pad_blk;
  logic [CNT_W-1:0] zero_cnt;
  logic [7:0]       pv;
  logic             all_ok;
  logic             pv_ok;
  logic             chk_ok;
  res_t             err_res;
  res_t             pass_res;
  res_t             held_res;
  res_t             fin_res;

  always_comb begin
    zero_cnt = '0;
    all_ok   = 1'b1;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      add_blk[8*i +: 8]   = lanes_i[i].add_byte;
      strip_blk[8*i +: 8] = lanes_i[i].strip_byte;
      if (mode_i == PAD_PKCS7 || (mode_i == PAD_X923 && i == BLOCK_BYTES - 1)) begin
        pad_blk[8*i +: 8] = 8'(BLOCK_BYTES);
      end else begin
        pad_blk[8*i +: 8] = 8'h00;
      end
      if (lanes_i[i].nz) begin
        zero_cnt = CNT_W'(i + 1);
      end
      all_ok = all_ok & lanes_i[i].ok;
    end
    pv     = blk_i[BLK_W-1 -: 8];
    pv_ok  = pv != 8'h00 && pv <= 8'(BLOCK_BYTES);
    chk_ok = (mode_i == PAD_ZERO) || (pv_ok && all_ok);

    err_res  = '{blk: '0, count: '0, last: last_i, err: 1'b1};
    pass_res = '{blk: blk_i, count: FULL_CNT, last: 1'b0, err: 1'b0};
    held_res = '{blk: held_blk_i, count: FULL_CNT, last: 1'b0, err: 1'b0};
    if (mode_i == PAD_ZERO) begin
      fin_res = '{blk: blk_i, count: zero_cnt, last: 1'b1, err: 1'b0};
    end else begin
      fin_res = '{blk: strip_blk, count: FULL_CNT - CNT_W'(pv), last: 1'b1, err: 1'b0};
    end

    n_res_o = 2'd1;
    res0_o  = err_res;
    res1_o  = err_res;
    held_o  = '{load: 1'b0, clr: 1'b1};

    if (mode_i != PAD_BAD) begin
      if (dir_i == DIR_ADD) begin
        if (!last_i) begin
          if (count_i == FULL_CNT) begin
            res0_o = pass_res;
            held_o = '0;
          end
        end else if (count_i == FULL_CNT) begin
          n_res_o = 2'd2;
          res0_o  = pass_res;
          res1_o  = '{blk: pad_blk, count: FULL_CNT, last: 1'b1, err: 1'b0};
          held_o  = '0;
        end else if (count_i < FULL_CNT) begin
          res0_o = '{blk: add_blk, count: FULL_CNT, last: 1'b1, err: 1'b0};
          held_o = '0;
        end
      end else if (count_i == FULL_CNT) begin
        if (!last_i) begin
          n_res_o = held_valid_i ? 2'd1 : 2'd0;
          res0_o  = held_res;
          held_o  = '{load: 1'b1, clr: 1'b0};
        end else if (chk_ok) begin
          if (held_valid_i) begin
            n_res_o = 2'd2;
            res0_o  = held_res;
            res1_o  = fin_res;
          end else begin
            res0_o = fin_res;
          end
        end
      end
    end
  end

endmodule

// ===== sv/bcpe_ofifo.sv =====
`timescale 1ns / 1ps
module bcpe_ofifo
  import bcpe_pkg::*;
#(
  parameter int Depth = OUT_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  res_t       push0_i,
  input  res_t       push1_i,
  output logic       room2_o,
  output logic       valid_o,
  input  logic       ready_i,
  output res_t       head_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  res_t          mem_q [Depth];
  logic [AW-1:0] wptr_q, wptr_d, wptr1;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    pop     = valid_o && ready_i;
    wptr1   = inc(wptr_q);
    wptr_d  = wptr_q;
    if (push_n_i == 2'd1) begin
      wptr_d = wptr1;
    end else if (push_n_i == 2'd2) begin
      wptr_d = inc(wptr1);
    end
    rptr_d  = pop ? inc(rptr_q) : rptr_q;
    cnt_d   = cnt_q + CW'(push_n_i) - CW'(pop);
  end

  assign valid_o = cnt_q != '0;
  assign room2_o = cnt_q <= CW'(Depth - 2);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wptr1] <= push1_i;
    end
  end

endmodule
